// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the RTL files that check their own behaviour.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define TEPE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define TEPE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/core/tepe_pkg.sv =====
// Package: sizes, constant tables, state and control types of the embedding block.
`timescale 1ns / 1ps
package tepe_pkg;

  localparam int EMBED_DIM    = 64;
  localparam int NUM_TOKENS   = 1024;
  localparam int MAX_POSITION = 4095;

  localparam int CMD_W  = 1;
  localparam int TOK_W  = 10;
  localparam int ELEM_W = 6;
  localparam int VAL_W  = 16;
  localparam int POS_W  = 12;
  localparam int ROW_W  = $clog2(NUM_TOKENS);
  localparam int ADDR_W = ROW_W + ELEM_W;
  localparam int RAM_DEPTH = NUM_TOKENS << ELEM_W;

  localparam int  N_PAIRS = EMBED_DIM / 2;
  localparam int  K_W     = (N_PAIRS > 1) ? $clog2(N_PAIRS) : 1;
  localparam bit  ODD_DIM = (EMBED_DIM % 2) == 1;
  localparam int  N_TERMS = 17;
  localparam int  I_W     = 5;

  localparam logic [63:0] LOG2_10000_Q28 = 64'd3566893131;
  localparam logic [63:0] LN2_Q30        = 64'd744261118;
  localparam logic [63:0] INV_TWO_PI_Q32 = 64'd683565276;
  localparam logic [30:0] HALF_PI_Q30    = 31'd1686629713;
  localparam logic [63:0] ONE_Q30        = 64'd1 << 30;

  localparam logic [CMD_W-1:0] CMD_WRITE  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 1'b1;

  typedef logic [39:0] freq_tab_t [N_PAIRS];
  typedef logic [32:0] recip_tab_t [2**I_W];

  // Turns per position of each pair, Q40, worked out at elaboration.
  function automatic freq_tab_t build_freq();
    freq_tab_t   tab;
    logic [63:0] t;
    logic [63:0] x;
    logic [63:0] term;
    longint      sum;
    int          n;
    for (int k = 0; k < N_PAIRS; k++) begin
      t    = (LOG2_10000_Q28 * 64'(2 * k)) / 64'(EMBED_DIM);
      n    = int'(t >> 28) & 31;
      x    = ((t & 64'hFFFFFFF) * LN2_Q30) >> 28;
      sum  = longint'(ONE_Q30);
      term = ONE_Q30;
      for (int i = 1; i <= 16; i++) begin
        term = ((term * x) >> 30) / 64'(i);
        if ((i % 2) == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      if (sum > longint'(ONE_Q30)) sum = longint'(ONE_Q30);
      tab[k] = 40'((64'(sum) * INV_TWO_PI_Q32) >> (22 + n));
    end
    return tab;
  endfunction

  // Reciprocals rounded up, ceil(2^32 / i), for the series divisions.
  function automatic recip_tab_t build_recip();
    recip_tab_t tab;
    for (int i = 0; i < 2**I_W; i++) begin
      if (i == 0) tab[i] = 33'd1;
      else tab[i] = 33'(((64'd1 << 32) + 64'(i) - 64'd1) / 64'(i));
    end
    return tab;
  endfunction

  localparam freq_tab_t  FREQ_TAB  = build_freq();
  localparam recip_tab_t RECIP_TAB = build_recip();

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PHASE,
    ST_RAD,
    ST_MUL,
    ST_RCP,
    ST_FIX,
    ST_ROUND,
    ST_WAIT0,
    ST_EMIT0,
    ST_WAIT1,
    ST_EMIT1
  } tepe_state_t;

  typedef struct packed {
    logic start;
    logic write;
    logic phase;
    logic rad;
    logic mul;
    logic rcp;
    logic fix;
    logic round;
    logic emit;
  } tepe_cmd_t;

  typedef struct packed {
    logic i_done;
    logic out_free;
    logic last_elem;
    logic tail_next;
  } tepe_sts_t;

endpackage

// ===== rtl/core/tepe_in_if.sv =====
// Input channel interface: valid/ready handshake with a write or lookup item.
`timescale 1ns / 1ps
interface tepe_in_if;
  import tepe_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic [TOK_W-1:0]        token_id;
  logic [ELEM_W-1:0]       element_index;
  logic signed [VAL_W-1:0] write_value;
  logic                    sequence_start;
  modport source (output valid, command, token_id, element_index, write_value,
                  sequence_start, input ready);
  modport sink (input valid, command, token_id, element_index, write_value,
                sequence_start, output ready);
endinterface

// ===== rtl/core/tepe_out_if.sv =====
// Result channel interface: valid/ready handshake with one embedding element.
`timescale 1ns / 1ps
interface tepe_out_if;
  import tepe_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] value;
  logic [ELEM_W-1:0]       element_index_res;
  logic [POS_W-1:0]        position;
  logic                    last;
  modport source (output valid, value, element_index_res, position, last, input ready);
  modport sink (input valid, value, element_index_res, position, last, output ready);
endinterface

// ===== rtl/core/token_embedding_with_positional_encoding.sv =====
// Top level: token embedding lookup with sinusoidal positional encoding.
//
//   channel  direction  handshake      item
//   in_ch    sink       valid / ready  table write or token lookup
//   out_ch   source     valid / ready  one embedding element plus positional term
//
// A write item is taken while idle and produces nothing. A lookup item holds the
// input closed while each element pair runs through the phase, angle, series
// (multiply, reciprocal, fix per term), rounding and two emit steps, until the
// whole row is out; the 17-term sine/cosine series, run through one shared multiplier
// and reciprocal divider, makes up most of this work.
// Reset is synchronous and active low; it clears the position counter and control.
// The table is undefined until written. A stalled output holds the sequencer.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module token_embedding_with_positional_encoding (
  input logic       clk,
  input logic       rst_n,
  tepe_in_if.sink   in_ch,
  tepe_out_if.source out_ch
);
  import tepe_pkg::*;

  tepe_cmd_t cmd;
  tepe_sts_t sts;

  // The controller only decides when each datapath step runs; all arithmetic,
  // the table memory and the output register live in the datapath.
  tepe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_lookup (in_ch.command == CMD_LOOKUP),
    .sts       (sts),
    .cmd       (cmd),
    .in_ready  (in_ch.ready)
  );

  tepe_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .in_token_id           (in_ch.token_id),
    .in_element_index      (in_ch.element_index),
    .in_write_value        (in_ch.write_value),
    .in_sequence_start     (in_ch.sequence_start),
    .out_valid             (out_ch.valid),
    .out_ready             (out_ch.ready),
    .out_value             (out_ch.value),
    .out_element_index_res (out_ch.element_index_res),
    .out_position          (out_ch.position),
    .out_last              (out_ch.last)
  );

  // An element is only loaded when the output register is free.
  `TEPE_ASSERT_IMP(a_emit_free, cmd.emit, sts.out_free)
  // A loaded element is offered in the following cycle.
  `TEPE_ASSERT_NXT(a_emit_shown, cmd.emit, out_ch.valid)
  // Once a lookup is taken the input stays closed while the series runs.
  `TEPE_ASSERT_NXT(a_lookup_busy, cmd.start, !in_ch.ready)
endmodule

// ===== rtl/core/tepe_ram.sv =====
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
module tepe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/core/tepe_ctrl.sv =====
// Controller: sequences the positional term series and the element emission.
`timescale 1ns / 1ps
module tepe_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_lookup,
  input  tepe_pkg::tepe_sts_t sts,
  output tepe_pkg::tepe_cmd_t cmd,
  output logic                in_ready
);
  import tepe_pkg::*;

  tepe_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_lookup) state_nxt = ST_PHASE;
      end
      ST_PHASE: state_nxt = ST_RAD;
      ST_RAD:   state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_RCP;
      ST_RCP:   state_nxt = ST_FIX;
      ST_FIX: begin
        state_nxt = sts.i_done ? ST_ROUND : ST_MUL;
      end
      ST_ROUND: state_nxt = ST_WAIT0;
      ST_WAIT0: state_nxt = ST_EMIT0;
      ST_EMIT0: begin
        if (sts.out_free) state_nxt = sts.last_elem ? ST_IDLE : ST_WAIT1;
      end
      ST_WAIT1: state_nxt = ST_EMIT1;
      ST_EMIT1: begin
        if (sts.out_free) begin
          if (sts.last_elem) state_nxt = ST_IDLE;
          else if (sts.tail_next) state_nxt = ST_WAIT0;
          else state_nxt = ST_PHASE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid && in_lookup;
        cmd.write = in_valid && !in_lookup;
      end
      ST_PHASE: cmd.phase = 1'b1;
      ST_RAD:   cmd.rad   = 1'b1;
      ST_MUL:   cmd.mul   = 1'b1;
      ST_RCP:   cmd.rcp   = 1'b1;
      ST_FIX:   cmd.fix   = 1'b1;
      ST_ROUND: cmd.round = 1'b1;
      ST_EMIT0: cmd.emit  = sts.out_free;
      ST_EMIT1: cmd.emit  = sts.out_free;
      default: ;
    endcase
  end
endmodule

// ===== rtl/core/tepe_dp.sv =====
// Datapath: table memory, position counter, sine/cosine series unit and output register.
`timescale 1ns / 1ps
module tepe_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tepe_pkg::tepe_cmd_t              cmd,
  output tepe_pkg::tepe_sts_t              sts,
  input  logic [tepe_pkg::TOK_W-1:0]       in_token_id,
  input  logic [tepe_pkg::ELEM_W-1:0]      in_element_index,
  input  logic signed [tepe_pkg::VAL_W-1:0] in_write_value,
  input  logic                             in_sequence_start,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [tepe_pkg::VAL_W-1:0] out_value,
  output logic [tepe_pkg::ELEM_W-1:0]      out_element_index_res,
  output logic [tepe_pkg::POS_W-1:0]       out_position,
  output logic                             out_last
);
  import tepe_pkg::*;

  function automatic logic [12:0] round_q12(input logic signed [35:0] v);
    logic signed [35:0] cl;
    logic [35:0]        sum;
    cl = v;
    if (v < 0) cl = '0;
    if (v > 36'sd1073741824) cl = 36'sd1073741824;
    sum = 36'(cl) + 36'd131072;
    return sum[30:18];
  endfunction

  logic [TOK_W-1:0]        tok_r;
  logic                    zero_row_r;
  logic [POS_W-1:0]        pos_r, pos_cnt_r, pos_use;
  logic [ELEM_W-1:0]       j_r;
  logic [39:0]             phase_r;
  logic [30:0]             r_r, term_r;
  logic [31:0]             p_r;
  logic [61:0]             prod_r;
  logic [63:0]             m_r;
  logic [I_W-1:0]          i_r;
  logic signed [35:0]      s_r, c_r;
  logic signed [13:0]      sn_r, cs_r;
  logic                    out_valid_r;
  logic signed [VAL_W-1:0] value_r;
  logic [ELEM_W-1:0]       elem_r;
  logic [POS_W-1:0]        opos_r;
  logic                    last_r;

  logic [51:0]             phase_full;
  logic [60:0]             r_full;
  logic [31:0]             p_w, q0, q_adj;
  logic [30:0]             q;
  logic [35:0]             chk;
  logic signed [35:0]      q_s;
  logic [12:0]             s12, c12;
  logic                    wr_ok, we;
  logic [ADDR_W-1:0]       addr;
  logic [VAL_W-1:0]        rdata;
  logic signed [VAL_W-1:0] word;
  logic signed [13:0]      pterm;
  logic signed [16:0]      vsum;
  logic signed [VAL_W-1:0] vsat;

  assign wr_ok = (32'(in_token_id) < 32'(NUM_TOKENS)) &&
                 (32'(in_element_index) < 32'(EMBED_DIM));
  assign we    = cmd.write && wr_ok;
  assign addr  = we ? {in_token_id[ROW_W-1:0], in_element_index}
                    : {tok_r[ROW_W-1:0], j_r};

  tepe_ram #(.WIDTH(VAL_W), .DEPTH(RAM_DEPTH)) u_table (
    .clk   (clk),
    .we    (we),
    .addr  (addr),
    .wdata (in_write_value),
    .rdata (rdata)
  );

  // The product of a term and the angle can reach 2^61, so the shifted value
  // keeps 32 bits before the division by the term number.
  assign pos_use    = in_sequence_start ? '0 : pos_cnt_r;
  assign phase_full = 52'(pos_r) * 52'(FREQ_TAB[j_r[K_W:1]]);
  assign r_full     = 61'(phase_r[37:8]) * 61'(HALF_PI_Q30);
  assign p_w        = prod_r[61:30];
  assign q0         = m_r[63:32];
  assign chk        = 36'(q0) * 36'(i_r);
  assign q_adj      = (chk > 36'(p_r)) ? q0 - 32'd1 : q0;
  assign q          = q_adj[30:0];
  assign q_s        = $signed({5'b0, q});
  assign s12        = round_q12(s_r);
  assign c12        = round_q12(c_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_cnt_r <= '0;
    end else if (cmd.start) begin
      pos_cnt_r <= (32'(pos_use) >= 32'(MAX_POSITION)) ? POS_W'(MAX_POSITION)
                                                      : pos_use + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      tok_r      <= in_token_id;
      zero_row_r <= !(32'(in_token_id) < 32'(NUM_TOKENS));
      pos_r      <= pos_use;
      j_r        <= '0;
    end
    if (cmd.emit) j_r <= j_r + ELEM_W'(1);
    if (cmd.phase) phase_r <= phase_full[39:0];
    if (cmd.rad) begin
      r_r    <= r_full[60:30];
      term_r <= 31'(ONE_Q30);
      s_r    <= '0;
      c_r    <= 36'sd1073741824;
      i_r    <= I_W'(1);
    end
    if (cmd.mul) prod_r <= 62'(term_r) * 62'(r_r);
    if (cmd.rcp) begin
      p_r <= p_w;
      m_r <= 64'(p_w) * 64'(RECIP_TAB[i_r]);
    end
    if (cmd.fix) begin
      term_r <= q;
      i_r    <= i_r + I_W'(1);
      case (i_r[1:0])
        2'b01:   s_r <= s_r + q_s;
        2'b10:   c_r <= c_r - q_s;
        2'b11:   s_r <= s_r - q_s;
        default: c_r <= c_r + q_s;
      endcase
    end
    if (cmd.round) begin
      case (phase_r[39:38])
        2'b00: begin
          sn_r <= $signed({1'b0, s12});
          cs_r <= $signed({1'b0, c12});
        end
        2'b01: begin
          sn_r <= $signed({1'b0, c12});
          cs_r <= -$signed({1'b0, s12});
        end
        2'b10: begin
          sn_r <= -$signed({1'b0, s12});
          cs_r <= -$signed({1'b0, c12});
        end
        default: begin
          sn_r <= -$signed({1'b0, c12});
          cs_r <= $signed({1'b0, s12});
        end
      endcase
    end
  end

  // Element sum, with no positional term on the odd tail element.
  assign word  = zero_row_r ? '0 : $signed(rdata);
  assign pterm = (ODD_DIM && sts.last_elem) ? '0 : (j_r[0] ? cs_r : sn_r);
  assign vsum  = {word[VAL_W-1], word} + {{3{pterm[13]}}, pterm};
  always_comb begin
    vsat = vsum[VAL_W-1:0];
    if (vsum > 17'sd32767) vsat = 16'sh7FFF;
    if (vsum < -17'sd32768) vsat = 16'sh8000;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      value_r <= vsat;
      elem_r  <= j_r;
      opos_r  <= pos_r;
      last_r  <= sts.last_elem;
    end
  end

  assign sts.i_done    = i_r == I_W'(N_TERMS);
  assign sts.out_free  = !out_valid_r || out_ready;
  assign sts.last_elem = j_r == ELEM_W'(EMBED_DIM - 1);
  assign sts.tail_next = ODD_DIM && (j_r == ELEM_W'(EMBED_DIM - 2));

  assign out_valid             = out_valid_r;
  assign out_value             = value_r;
  assign out_element_index_res = elem_r;
  assign out_position          = opos_r;
  assign out_last              = last_r;
endmodule

// ===== tb/token_embedding_with_positional_encoding_checker.sv =====
// Checker: watches both channels, predicts every embedding element and compares.
`timescale 1ns / 1ps
module token_embedding_with_positional_encoding_checker (
  input logic clk,
  input logic rst_n,
  tepe_in_if  in_mon,
  tepe_out_if out_mon,
  output int  errors,
  output int  pending,
  output int  results_seen
);
  import tepe_pkg::*;

  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic [ELEM_W-1:0]       elem;
    logic [POS_W-1:0]        pos;
    logic                    last;
  } elem_res_t;

  logic [VAL_W-1:0] table_words [NUM_TOKENS * EMBED_DIM];
  logic [POS_W-1:0] next_pos;
  elem_res_t        expected_elems [$];

  // Angular rate of pair k, in turns per position scaled by 2^40.
  function automatic longint unsigned turn_rate(int k);
    longint unsigned t, x, term;
    longint          acc;
    int              n;
    t    = (LOG2_10000_Q28 * 64'(2 * k)) / 64'(EMBED_DIM);
    n    = int'(t >> 28) & 31;
    x    = ((t & 64'hFFFFFFF) * LN2_Q30) >> 28;
    acc  = longint'(ONE_Q30);
    term = ONE_Q30;
    for (int i = 1; i <= 16; i++) begin
      term = ((term * x) >> 30) / 64'(i);
      if (i % 2 == 1) acc -= longint'(term);
      else acc += longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > longint'(ONE_Q30)) acc = longint'(ONE_Q30);
    return (longint'(acc) * INV_TWO_PI_Q32) >> (22 + n);
  endfunction

  function automatic int to_q12(longint v);
    if (v < 0) v = 0;
    if (v > longint'(ONE_Q30)) v = longint'(ONE_Q30);
    return int'((v + (64'd1 << 17)) >> 18);
  endfunction

  task automatic sin_cos(input logic [39:0] phase, output int sn, output int cs);
    longint unsigned r, term;
    longint          s, c;
    int              s12, c12;
    r    = (64'(phase[37:0] >> 8) * 64'(HALF_PI_Q30)) >> 30;
    s    = 0;
    c    = longint'(ONE_Q30);
    term = ONE_Q30;
    for (int i = 1; i <= 17; i++) begin
      term = ((term * r) >> 30) / 64'(i);
      case (i % 4)
        1: s += longint'(term);
        2: c -= longint'(term);
        3: s -= longint'(term);
        default: c += longint'(term);
      endcase
    end
    s12 = to_q12(s);
    c12 = to_q12(c);
    case (phase[39:38])
      2'd0: begin sn = s12;  cs = c12;  end
      2'd1: begin sn = c12;  cs = -s12; end
      2'd2: begin sn = -s12; cs = -c12; end
      default: begin sn = -c12; cs = s12; end
    endcase
  endtask

  // One lookup yields a full row; sine and cosine of a pair share one angle.
  task automatic predict_row(input logic [TOK_W-1:0] tok, input logic restart);
    logic [POS_W-1:0] p;
    logic [39:0]      phase;
    elem_res_t        e;
    int               sn, cs, v, term;
    p = restart ? '0 : next_pos;
    for (int j = 0; j < EMBED_DIM; j++) begin
      term = 0;
      if (j / 2 < N_PAIRS) begin
        if (j % 2 == 0) begin
          phase = 40'(64'(p) * turn_rate(j / 2));
          sin_cos(phase, sn, cs);
          term = sn;
        end else begin
          term = cs;
        end
      end
      v = int'($signed(table_words[int'(tok) * EMBED_DIM + j])) + term;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      e.value = VAL_W'(v);
      e.elem  = ELEM_W'(j);
      e.pos   = p;
      e.last  = (j == EMBED_DIM - 1);
      expected_elems.push_back(e);
    end
    next_pos = (int'(p) >= MAX_POSITION) ? POS_W'(MAX_POSITION) : p + 1'b1;
  endtask

  assign pending = expected_elems.size();

  always @(posedge clk) begin
    elem_res_t e;
    if (!rst_n) begin
      next_pos = '0;
      errors       <= 0;
      results_seen <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.command == CMD_WRITE)
          table_words[int'(in_mon.token_id) * EMBED_DIM + int'(in_mon.element_index)] =
            in_mon.write_value;
        else
          predict_row(in_mon.token_id, in_mon.sequence_start);
      end
      if (out_mon.valid && out_mon.ready) begin
        results_seen <= results_seen + 1;
        if (expected_elems.size() == 0) begin
          if (errors < 10) $display("unexpected element %0d value %0d",
                                    out_mon.element_index_res, out_mon.value);
          errors <= errors + 1;
        end else begin
          e = expected_elems.pop_front();
          if (out_mon.value !== e.value || out_mon.element_index_res !== e.elem ||
              out_mon.position !== e.pos || out_mon.last !== e.last) begin
            if (errors < 10)
              $display("element mismatch v/el/pos/last: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                       e.value, e.elem, e.pos, e.last, out_mon.value,
                       out_mon.element_index_res, out_mon.position, out_mon.last);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

// ===== tb/token_embedding_with_positional_encoding_test.sv =====
// Testbench top: drives table writes and token lookups and gives the verdict.
`timescale 1ns / 1ps
module token_embedding_with_positional_encoding_test;
  import tepe_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int LONG_HOLD   = 6000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   cycles = 0;
  int   errors, pending, results_seen;
  int   n_writes = 0, n_lookups = 0;
  int   hold_requests = 0, holds_done = 0, hold_cnt = 0;
  int   burst_left = 0, stall_mode = 0, mode_cnt = 0;

  // Which words of each row have been written; only complete rows are looked up,
  // since a never-written word has no defined value.
  bit   written [NUM_TOKENS][EMBED_DIM];
  int   full_rows [$];
  int   fill_elem;

  tepe_in_if  in_ch ();
  tepe_out_if out_ch ();

  token_embedding_with_positional_encoding i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  token_embedding_with_positional_encoding_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .errors      (errors),
    .pending     (pending),
    .results_seen(results_seen)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The run is bounded by a cycle counter so that a hung block still ends it.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("token_embedding_with_positional_encoding: mismatch");
      $finish;
    end
  end

  // The receiver changes its stall behaviour at random intervals: sometimes it
  // never stalls, sometimes lightly and sometimes heavily. On request it holds off
  // for a long stretch so that the block fills up and must stall its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt     <= hold_cnt - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_requests != holds_done) begin
      holds_done   <= holds_done + 1;
      hold_cnt     <= LONG_HOLD;
      out_ch.ready <= 1'b0;
    end else begin
      if (mode_cnt == 0) begin
        mode_cnt   <= $urandom_range(50, 400);
        stall_mode <= $urandom_range(0, 2);
      end else begin
        mode_cnt <= mode_cnt - 1;
      end
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        default: out_ch.ready <= ($urandom_range(0, 9) < 3);
      endcase
    end
  end

  // Offers one item and waits for it to be accepted. Valid stays high afterwards
  // inside a burst; between bursts it drops for a random gap.
  task automatic offer(input logic [CMD_W-1:0] cmd, input int tok, input int el,
                       input int val, input bit restart);
    int gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid          <= 1'b1;
    in_ch.command        <= cmd;
    in_ch.token_id       <= TOK_W'(tok);
    in_ch.element_index  <= ELEM_W'(el);
    in_ch.write_value    <= VAL_W'(val);
    in_ch.sequence_start <= restart;
    do @(posedge clk); while (!in_ch.ready);
    if (cmd == CMD_WRITE) begin
      n_writes++;
      if (!written[tok][el]) begin
        written[tok][el] = 1'b1;
        fill_elem = 0;
        for (int j = 0; j < EMBED_DIM; j++) fill_elem += written[tok][j];
        if (fill_elem == EMBED_DIM) full_rows.push_back(tok);
      end
    end else begin
      n_lookups++;
    end
  endtask

  task automatic fill_whole_row(input int tok, input int val);
    for (int j = 0; j < EMBED_DIM; j++) offer(CMD_WRITE, tok, j, val, 1'b0);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int pick;
    in_ch.valid          <= 1'b0;
    in_ch.command        <= CMD_WRITE;
    in_ch.token_id       <= '0;
    in_ch.element_index  <= '0;
    in_ch.write_value    <= '0;
    in_ch.sequence_start <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: rows of the extreme words, so the positional term drives the
    // sums into saturation at both ends, then lookups with and without a restart.
    fill_whole_row(0, 32767);
    fill_whole_row(NUM_TOKENS - 1, -32768);
    offer(CMD_LOOKUP, 0, 0, 0, 1'b1);
    offer(CMD_LOOKUP, NUM_TOKENS - 1, 0, 0, 1'b0);
    // A write straight behind a lookup changes the row for the next lookup only.
    offer(CMD_WRITE, 0, EMBED_DIM - 1, 0, 1'b0);
    offer(CMD_WRITE, 0, 0, -1, 1'b0);
    offer(CMD_LOOKUP, 0, 0, 0, 1'b0);
    offer(CMD_LOOKUP, 0, 0, 0, 1'b1);
    wait_drained();

    // Long hold-off on the result side while lookups keep coming.
    hold_requests <= hold_requests + 1;
    offer(CMD_LOOKUP, NUM_TOKENS - 1, 0, 0, 1'b0);
    offer(CMD_LOOKUP, 0, 0, 0, 1'b0);
    offer(CMD_LOOKUP, NUM_TOKENS - 1, 0, 0, 1'b0);
    wait_drained();

    // Random part: lookups of complete rows at random positions, mixed with stray
    // writes of random words anywhere in the table.
    for (int n = 0; n < 16; n++) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        offer(CMD_LOOKUP, full_rows[$urandom_range(0, full_rows.size() - 1)], 0, 0,
              ($urandom_range(0, 7) == 0));
      end else begin
        offer(CMD_WRITE, $urandom_range(0, NUM_TOKENS - 1), $urandom_range(0, EMBED_DIM - 1),
              $urandom_range(0, 65535), 1'($urandom_range(0, 1)));
      end
      if (n == 7) wait_drained();
    end

    wait_drained();
    repeat (100) @(posedge clk);
    $display("run covered %0d table writes and %0d lookups over %0d complete rows",
             n_writes, n_lookups, full_rows.size());
    $display("%0d embedding elements checked", results_seen);
    if (errors == 0) begin
      $display("token_embedding_with_positional_encoding: match");
    end else begin
      $display("token_embedding_with_positional_encoding: mismatch");
    end
    $finish;
  end
endmodule
